// ----- rtl/hsbd_pkg.sv -----
// hsbd_pkg: shared types and constants of the histogram shot boundary detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hsbd_pkg;

  localparam int unsigned BIN_W      = 6;
  localparam int unsigned BIN_COUNT  = 64;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 22;
  localparam int unsigned DIST_W     = 23;
  localparam int unsigned THR_W      = 23;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned FRAME_W    = 24;
  localparam int unsigned ACC_W      = 28;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
  localparam logic [DIST_W-1:0] DIST_MAX     = '1;
  localparam logic [THR_W-1:0]  CUT_THR_RST  = THR_W'(160000);
  localparam logic [THR_W-1:0]  GRAD_THR_RST = THR_W'(20000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUT_THR  = 1'b0,
    REG_GRAD_THR = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_WALK,
    ST_WDRAIN,
    ST_CMP
  } back_state_e;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             eof;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/hsbd_pix_if.sv -----
// hsbd_pix_if: pixel channel, valid/ready with one pixel per transaction
// depends on hsbd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hsbd_pix_if;
  import hsbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_blue;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_red;
  logic             end_of_frame;

  modport source (
    output valid, pixel_blue, pixel_green, pixel_red, end_of_frame,
    input  ready
  );

  modport sink (
    input  valid, pixel_blue, pixel_green, pixel_red, end_of_frame,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/hsbd_res_if.sv -----
// hsbd_res_if: per-frame result channel, valid/ready
// depends on hsbd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hsbd_res_if;
  import hsbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_number;
  logic [DIST_W-1:0]  frame_distance;
  logic [SUM_W-1:0]   accumulated_change;
  logic               cut_found;

  modport source (
    output valid, frame_number, frame_distance, accumulated_change, cut_found,
    input  ready
  );

  modport sink (
    input  valid, frame_number, frame_distance, accumulated_change, cut_found,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/hsbd_front.sv -----
// hsbd_front: accepts pixels, forms the 64-bin colour index, registers the item
// depends on hsbd_pkg, hsbd_pix_if
`timescale 1ns / 1ps
`default_nettype none

module hsbd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  hsbd_pix_if.sink           pix_i,
  output logic               item_valid_o,
  input  wire logic          item_ready_i,
  output hsbd_pkg::item_t    item_o
);
  import hsbd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign pix_i.ready = !valid_q || item_ready_i;
  assign take        = pix_i.valid && pix_i.ready;
  assign valid_d     = take || (valid_q && !item_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // top two bits of blue, green and red
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.bin <= {pix_i.pixel_blue[PIX_W-1 -: 2], pix_i.pixel_green[PIX_W-1 -: 2],
                     pix_i.pixel_red[PIX_W-1 -: 2]};
      item_q.eof <= pix_i.end_of_frame;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ----- rtl/hsbd_queue.sv -----
// hsbd_queue: short fifo of classified pixels between front and back
// depends on hsbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsbd_queue #(
  parameter int unsigned DEPTH = hsbd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hsbd_pkg::item_t  in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hsbd_pkg::item_t       out_item_o
);
  import hsbd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         slot_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o  = cnt_q != CW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hsbd_back.sv -----
// hsbd_back: histogram banks, end-of-frame L1 walk, twin comparison, result register
// depends on hsbd_pkg, hsbd_res_if
`timescale 1ns / 1ps
`default_nettype none

module hsbd_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [hsbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [hsbd_pkg::THR_W-1:0]        cfg_data_i,
  input  wire logic                              item_valid_i,
  output logic                                   item_ready_o,
  input  wire hsbd_pkg::item_t                   item_i,
  hsbd_res_if.source                             res_o
);
  import hsbd_pkg::*;

  back_state_e state_q, state_d;

  logic [THR_W-1:0] cut_thr_q, grad_thr_q;

  // histogram banks, two ping-pong memories with per-entry valid bits
  logic [CNT_W-1:0]     mem0 [BIN_COUNT];
  logic [CNT_W-1:0]     mem1 [BIN_COUNT];
  logic [BIN_COUNT-1:0] vld0_q, vld1_q;
  logic [CNT_W-1:0]     rd0_q, rd1_q;
  logic                 rv0_q, rv1_q;
  logic                 cur_q;
  logic [BIN_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     val0, val1, cur_val, prv_val;

  // count stage
  logic             s_v_q, s_eof_q;
  logic [BIN_W-1:0] s_bin_q;
  logic             fwd_v_q;
  logic [BIN_W-1:0] fwd_bin_q;
  logic [CNT_W-1:0] fwd_cnt_q;
  logic [CNT_W-1:0] src, inc;
  logic             accept;

  // walk
  logic [BIN_W-1:0] widx_q;
  logic             w_v_q;
  logic [ACC_W-1:0] acc_q;
  logic [CNT_W-1:0] absdiff;

  // twin comparison
  logic               first_q;
  logic [SUM_W-1:0]   sum_q, sum_acc;
  logic               act_q, act_n;
  logic [FRAME_W-1:0] frame_q;
  logic [DIST_W-1:0]  frame_dist, diff;
  logic               above, cut, cmp_go;
  logic [SUM_W:0]     sum_wide;

  logic               out_v_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [DIST_W-1:0]  out_dist_q;
  logic [SUM_W-1:0]   out_sum_q;
  logic               out_cut_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_thr_q  <= CUT_THR_RST;
      grad_thr_q <= GRAD_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CUT_THR:  cut_thr_q  <= cfg_data_i;
        REG_GRAD_THR: grad_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    cmp_go       = 1'b0;
    case (state_q)
      ST_RUN: begin
        item_ready_o = !(s_v_q && s_eof_q);
        if (s_v_q && s_eof_q) begin
          state_d = first_q ? ST_CMP : ST_WALK;
        end
      end
      ST_WALK: begin
        if (widx_q == BIN_W'(BIN_COUNT - 1)) begin
          state_d = ST_WDRAIN;
        end
      end
      ST_WDRAIN: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!out_v_q || res_o.ready) begin
          cmp_go  = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  assign accept = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // histogram read path
  assign rd_addr = (state_q == ST_WALK) ? widx_q : item_i.bin;
  assign val0    = rv0_q ? rd0_q : '0;
  assign val1    = rv1_q ? rd1_q : '0;
  assign cur_val = cur_q ? val1 : val0;
  assign prv_val = cur_q ? val0 : val1;

  assign src = (fwd_v_q && fwd_bin_q == s_bin_q) ? fwd_cnt_q : cur_val;
  assign inc = (src == CNT_MAX) ? src : src + 1'b1;

  always_ff @(posedge clk_i) begin
    if (s_v_q && !cur_q) begin
      mem0[s_bin_q] <= inc;
    end
    if (s_v_q && cur_q) begin
      mem1[s_bin_q] <= inc;
    end
    rd0_q <= mem0[rd_addr];
    rd1_q <= mem1[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q  <= '0;
      vld1_q  <= '0;
      rv0_q   <= 1'b0;
      rv1_q   <= 1'b0;
      cur_q   <= 1'b0;
      s_v_q   <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      rv0_q   <= vld0_q[rd_addr];
      rv1_q   <= vld1_q[rd_addr];
      s_v_q   <= accept;
      fwd_v_q <= s_v_q;
      if (s_v_q && !cur_q) begin
        vld0_q[s_bin_q] <= 1'b1;
      end
      if (s_v_q && cur_q) begin
        vld1_q[s_bin_q] <= 1'b1;
      end
      // the old previous bank becomes the new, empty current bank
      if (cmp_go) begin
        cur_q <= !cur_q;
        if (cur_q) begin
          vld0_q <= '0;
        end else begin
          vld1_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_bin_q <= item_i.bin;
      s_eof_q <= item_i.eof;
    end
    fwd_bin_q <= s_bin_q;
    fwd_cnt_q <= inc;
  end

  // L1 walk over both banks
  assign absdiff = (cur_val > prv_val) ? cur_val - prv_val : prv_val - cur_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      w_v_q  <= 1'b0;
    end else begin
      w_v_q <= state_q == ST_WALK;
      if (state_q == ST_WALK) begin
        widx_q <= widx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      acc_q <= '0;
    end else if (w_v_q) begin
      acc_q <= acc_q + ACC_W'(absdiff);
    end
  end

  // twin comparison
  always_comb begin
    if (first_q) begin
      frame_dist = '0;
    end else if (acc_q > ACC_W'(DIST_MAX)) begin
      frame_dist = DIST_MAX;
    end else begin
      frame_dist = acc_q[DIST_W-1:0];
    end
    above    = frame_dist > grad_thr_q;
    act_n    = act_q || above;
    diff     = above ? frame_dist - grad_thr_q : grad_thr_q - frame_dist;
    sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(diff);
    if (!act_n) begin
      sum_acc = sum_q;
    end else if (sum_wide[SUM_W]) begin
      sum_acc = '1;
    end else begin
      sum_acc = sum_wide[SUM_W-1:0];
    end
    cut = first_q || (frame_dist > cut_thr_q) || (sum_acc > SUM_W'(cut_thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      sum_q   <= '0;
      act_q   <= 1'b0;
      frame_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= cmp_go || (out_v_q && !res_o.ready);
      if (cmp_go) begin
        first_q <= 1'b0;
        frame_q <= frame_q + 1'b1;
        if (!first_q) begin
          sum_q <= cut ? '0 : sum_acc;
          act_q <= cut ? 1'b0 : act_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_go) begin
      out_frame_q <= frame_q;
      out_dist_q  <= frame_dist;
      out_sum_q   <= (first_q || cut) ? '0 : sum_acc;
      out_cut_q   <= cut;
    end
  end

  assign res_o.valid              = out_v_q;
  assign res_o.frame_number       = out_frame_q;
  assign res_o.frame_distance     = out_dist_q;
  assign res_o.accumulated_change = out_sum_q;
  assign res_o.cut_found          = out_cut_q;

`ifndef NO_ASSERTIONS
  a_new_bank_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_go |=> ((cur_q ? vld1_q : vld0_q) == '0))
    else $error("current bank not empty after swap");

  a_walk_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WDRAIN |-> widx_q == '0)
    else $error("walk index did not cover all bins");

  a_no_count_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RUN |-> !s_v_q)
    else $error("pixel in count stage outside run");

  a_cut_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_go && cut) |=> (sum_q == '0 && !act_q))
    else $error("cut did not clear gradual state");
`endif

endmodule

`default_nettype wire

// ----- rtl/histogram_shot_boundary_detector_unit.sv -----
// histogram_shot_boundary_detector_unit: top level, front, queue and back
// depends on hsbd_pkg, hsbd_pix_if, hsbd_res_if, hsbd_front, hsbd_queue, hsbd_back
//
//   channel  dir  handshake        payload
//   pix_i    in   valid / ready    pixel_blue, pixel_green, pixel_red, end_of_frame
//   res_o    out  valid / ready    frame_number, frame_distance, accumulated_change, cut_found
//   cfg      in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// pixels are counted at one per cycle, a read-modify-write of the current bank,
// except while the back walks the 64 bins through both bank read ports after a
// frame's last pixel (no walk on the first frame): it takes no pixel then, nor while
// the previous result still waits in the output register for res_o ready
// the queue keeps the front taking pixels during that walk until it fills
// reset clears bank valid bits at once, no clearing pass; a result waits in its register
`timescale 1ns / 1ps
`default_nettype none

module histogram_shot_boundary_detector_unit #(
  parameter int unsigned QUEUE_DEPTH = hsbd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  hsbd_pix_if.sink                             pix_i,
  hsbd_res_if.source                           res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [hsbd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hsbd_pkg::THR_W-1:0]      cfg_data_i
);
  import hsbd_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  hsbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  hsbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_item_o  (b_item)
  );

  hsbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_histogram_shot_boundary_detector_unit.sv -----
// tb_histogram_shot_boundary_detector_unit: directed and random frames checked against a
// predictor of the twin comparison shot detector, with idling, stalls and threshold changes
// depends on hsbd_pkg, hsbd_pix_if, hsbd_res_if and histogram_shot_boundary_detector_unit
`timescale 1ns / 1ps

module tb_histogram_shot_boundary_detector_unit;
  import hsbd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 100;
  localparam longint unsigned TIMEOUT_NS = 64'd6_000_000;
  localparam logic [THR_W-1:0] THR_TOP = '1;
  localparam logic [THR_W-1:0] THR_HALF = THR_W'(4194304);

  typedef struct {
    logic [FRAME_W-1:0] frame_number;
    logic [DIST_W-1:0]  frame_distance;
    logic [SUM_W-1:0]   accumulated_change;
    logic               cut_found;
  } shot_result_t;

  class shot_scoreboard;
    logic [CNT_W-1:0]   cur_bins[BIN_COUNT];
    logic [CNT_W-1:0]   prev_bins[BIN_COUNT];
    logic [SUM_W-1:0]   grad_sum;
    bit                 grad_active;
    logic [FRAME_W-1:0] frame_idx;
    bit                 first_pending;
    logic [THR_W-1:0]   cut_thr;
    logic [THR_W-1:0]   grad_thr;
    shot_result_t       expected_shots[$];
    int unsigned        fail_count;

    function new();
      foreach (cur_bins[i]) begin
        cur_bins[i] = '0;
        prev_bins[i] = '0;
      end
      grad_sum = '0;
      grad_active = 1'b0;
      frame_idx = '0;
      first_pending = 1'b1;
      cut_thr = CUT_THR_RST;
      grad_thr = GRAD_THR_RST;
      fail_count = 0;
    endfunction

    function void set_threshold(cfg_reg_e idx, logic [THR_W-1:0] value);
      if (idx == REG_CUT_THR) cut_thr = value;
      else grad_thr = value;
    endfunction

    function int unsigned pending();
      return expected_shots.size();
    endfunction

    // a transaction on the pixel channel
    function void note_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] r, logic eof);
      logic [BIN_W-1:0]  bin;
      longint unsigned   total;
      longint unsigned   grown;
      longint unsigned   step;
      logic [DIST_W-1:0] frame_dist;
      bit                is_cut;
      shot_result_t      shot;
      bin = {b[7:6], g[7:6], r[7:6]};
      if (cur_bins[bin] != CNT_MAX) cur_bins[bin] = cur_bins[bin] + 1'b1;
      if (!eof) return;
      frame_dist = '0;
      if (first_pending) begin
        first_pending = 1'b0;
        is_cut = 1'b1;
        shot.accumulated_change = '0;
      end else begin
        total = 0;
        for (int i = 0; i < BIN_COUNT; i++) begin
          if (cur_bins[i] > prev_bins[i]) total += longint'(cur_bins[i] - prev_bins[i]);
          else total += longint'(prev_bins[i] - cur_bins[i]);
        end
        frame_dist = (total > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(total);
        if (frame_dist > grad_thr) grad_active = 1'b1;
        if (grad_active) begin
          step = (frame_dist > grad_thr) ? longint'(frame_dist - grad_thr)
                                         : longint'(grad_thr - frame_dist);
          grown = longint'(grad_sum) + step;
          grad_sum = (grown > 64'hFFFF_FFFF) ? '1 : SUM_W'(grown);
        end
        is_cut = (frame_dist > cut_thr) || (grad_sum > SUM_W'(cut_thr));
        if (is_cut) begin
          grad_sum = '0;
          grad_active = 1'b0;
        end
        shot.accumulated_change = grad_sum;
      end
      shot.frame_number = frame_idx;
      shot.frame_distance = frame_dist;
      shot.cut_found = is_cut;
      expected_shots.insert(expected_shots.size(), shot);
      prev_bins = cur_bins;
      foreach (cur_bins[i]) cur_bins[i] = '0;
      frame_idx = frame_idx + 1'b1;
    endfunction

    // a transaction on the result channel
    function void check_shot(shot_result_t got);
      shot_result_t want;
      if (expected_shots.size() == 0) begin
        $error("unexpected result: frame_number %0d", got.frame_number);
        fail_count++;
        return;
      end
      want = expected_shots.pop_front();
      if (got.frame_number !== want.frame_number) begin
        $error("frame_number: expected %0d, actual %0d", want.frame_number, got.frame_number);
        fail_count++;
      end
      if (got.frame_distance !== want.frame_distance) begin
        $error("frame_distance: expected %0d, actual %0d",
               want.frame_distance, got.frame_distance);
        fail_count++;
      end
      if (got.accumulated_change !== want.accumulated_change) begin
        $error("accumulated_change: expected %0d, actual %0d",
               want.accumulated_change, got.accumulated_change);
        fail_count++;
      end
      if (got.cut_found !== want.cut_found) begin
        $error("cut_found: expected %0d, actual %0d", want.cut_found, got.cut_found);
        fail_count++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [THR_W-1:0]     cfg_data_i;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;
  shot_result_t seen_shot;
  shot_scoreboard sb = new();

  hsbd_pix_if pix ();
  hsbd_res_if res ();

  histogram_shot_boundary_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // receiver: random ready, plus a long hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      seen_shot.frame_number = res.frame_number;
      seen_shot.frame_distance = res.frame_distance;
      seen_shot.accumulated_change = res.accumulated_change;
      seen_shot.cut_found = res.cut_found;
      sb.check_shot(seen_shot);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel_blue <= b;
    pix.pixel_green <= g;
    pix.pixel_red <= r;
    pix.end_of_frame <= eof;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sb.note_pixel(b, g, r, eof);
  endtask

  task automatic send_frame(input int unsigned len, input logic [BIN_W-1:0] base_bin,
                            input int unsigned stray_pct);
    logic [PIX_W-1:0] b, g, r;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < stray_pct) begin
        b = PIX_W'($urandom);
        g = PIX_W'($urandom);
        r = PIX_W'($urandom);
      end else begin
        b = {base_bin[5:4], 6'($urandom)};
        g = {base_bin[3:2], 6'($urandom)};
        r = {base_bin[1:0], 6'($urandom)};
      end
      send_pixel(b, g, r, i == len - 1);
    end
  endtask

  // frames that mostly resemble the previous one, with drifting content
  task automatic run_frames(input int unsigned count, input int unsigned max_len);
    int unsigned      sent;
    int unsigned      len;
    int unsigned      stray;
    logic [BIN_W-1:0] base;
    sent = 0;
    base = BIN_W'($urandom);
    while (sent < count) begin
      if ($urandom_range(9) == 0) len = $urandom_range(1, 4 * max_len);
      else len = $urandom_range(1, max_len);
      if ($urandom_range(99) < 30) base = BIN_W'($urandom);
      stray = $urandom_range(1) ? $urandom_range(20) : $urandom_range(100);
      send_frame(len, base, stray);
      sent += len;
    end
    pix.valid <= 1'b0;
  endtask

  task automatic configure(input logic [THR_W-1:0] cut_value,
                           input logic [THR_W-1:0] grad_value);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_CUT_THR;
    cfg_data_i <= cut_value;
    @(posedge clk_i);
    cfg_idx_i <= REG_GRAD_THR;
    cfg_data_i <= grad_value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(REG_CUT_THR, cut_value);
    sb.set_threshold(REG_GRAD_THR, grad_value);
  endtask

  initial begin
    int unsigned guard;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CUT_THR;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.pixel_blue = '0;
    pix.pixel_green = '0;
    pix.pixel_red = '0;
    pix.end_of_frame = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 55;
    stall_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(THR_W'(12), THR_W'(3));
    // first frame of a single pixel, then an all-ones frame
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    // every 2-bit value on every channel, twice for a zero distance
    for (int k = 0; k < 2; k++) begin
      send_pixel(8'h3F, 8'h40, 8'h80, 1'b0);
      send_pixel(8'hC0, 8'h7F, 8'hBF, 1'b0);
      send_pixel(8'h80, 8'hC0, 8'h3F, 1'b0);
      send_pixel(8'h40, 8'h00, 8'hFF, 1'b0);
      send_pixel(8'h7F, 8'hBF, 8'hC0, 1'b0);
      send_pixel(8'hBF, 8'h3F, 8'h40, 1'b0);
      send_pixel(8'h00, 8'hFF, 8'h7F, 1'b0);
      send_pixel(8'hFF, 8'h80, 8'h00, 1'b1);
    end
    // a moderate change that starts accumulation
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h12, 1'b1);
    pix.valid <= 1'b0;

    configure(THR_W'($urandom_range(10, 40)), THR_W'($urandom_range(8)));
    run_frames(230, 24);

    send_idle_pct = 55;
    recv_idle_pct = 37;
    configure('0, '0);
    run_frames(150, 16);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(THR_TOP, THR_TOP);
    run_frames(80, 24);

    configure(THR_HALF, '0);
    run_frames(100, 24);

    // tiny frames while the receiver holds off, so the block backs up
    configure(THR_W'($urandom_range(6, 30)), THR_W'($urandom_range(6)));
    stall_left = 400;
    run_frames(100, 3);

    configure(THR_W'($urandom_range(10, 60)), THR_W'($urandom_range(10)));
    run_frames(120, 24);

    guard = 0;
    while (sb.pending() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hsbd_pkg.sv
rtl/hsbd_pix_if.sv
rtl/hsbd_res_if.sv
rtl/hsbd_front.sv
rtl/hsbd_queue.sv
rtl/hsbd_back.sv
rtl/histogram_shot_boundary_detector_unit.sv
tb/tb_histogram_shot_boundary_detector_unit.sv
